### hdl/kslt_pkg.sv
// Shared package for the keyed sequential list table.
// Holds field widths, the default capacity, op codes and status codes.
// No dependencies.
`timescale 1ns / 1ps

package kslt_pkg;

  localparam int KSLT_CAPACITY = 64;
  localparam int KEY_W         = 31;
  localparam int PAY_W         = 64;
  localparam int OP_W          = 4;
  localparam int ST_W          = 2;
  localparam int REC_W         = KEY_W + PAY_W;

  // Operation codes; codes ten to fifteen are unused.
  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT    = 4'd0,
    OP_INS_BACK     = 4'd1,
    OP_INS_SORTED   = 4'd2,
    OP_READ_POS     = 4'd3,
    OP_FIND_KEY     = 4'd4,
    OP_RM_KEY_SHIFT = 4'd5,
    OP_RM_KEY_SWAP  = 4'd6,
    OP_RM_FRONT     = 4'd7,
    OP_RM_BACK      = 4'd8,
    OP_READ_LAST    = 4'd9
  } kslt_op_e;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_NOTFOUND = 2'd2
  } kslt_st_e;

endpackage

### hdl/kslt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module kslt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/kslt_ctrl.sv
// Sequencer of the list table: walks the record RAM through one shared key
// comparator for search, ordered insert and removal by key.
// Depends on kslt_pkg; drives the ports of kslt_ram.
`timescale 1ns / 1ps

module kslt_ctrl import kslt_pkg::*; #(
  parameter int CAPACITY = KSLT_CAPACITY,
  localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // item channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [PAY_W-1:0]  payload_i,
  input  logic [CW-1:0]     position_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ST_W-1:0]   status_o,
  output logic [KEY_W-1:0]  out_key_o,
  output logic [PAY_W-1:0]  out_payload_o,
  output logic [CW-1:0]     count_o,
  output logic              full_res_o,
  output logic              empty_res_o,
  // record RAM
  output logic              ram_we_o,
  output logic [AW-1:0]     ram_waddr_o,
  output logic [REC_W-1:0]  ram_wdata_o,
  output logic [AW-1:0]     ram_raddr_o,
  input  logic [REC_W-1:0]  ram_rdata_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SHIFT, S_MV_RD, S_MV_WR, S_PUT, S_RD_ISSUE, S_RD_TAKE, S_FIN
  } state_e;

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  state_e            state_q, state_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [PAY_W-1:0]  pay_q, pay_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     ptr_q, ptr_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic              rv_q, rv_d;
  logic [CW-1:0]     ridx_q, ridx_d;
  logic [CW-1:0]     hit_q, hit_d;
  logic              hitv_q, hitv_d;
  logic [CW-1:0]     ins_q, ins_d;
  logic [AW-1:0]     src_q, src_d;
  logic [AW-1:0]     dst_q, dst_d;
  logic [ST_W-1:0]   st_q, st_d;
  logic [KEY_W-1:0]  rk_q, rk_d;
  logic [PAY_W-1:0]  rp_q, rp_d;
  logic              ovld_q, ovld_d;
  logic [ST_W-1:0]   ost_q, ost_d;
  logic [KEY_W-1:0]  okey_q, okey_d;
  logic [PAY_W-1:0]  opay_q, opay_d;
  logic [CW-1:0]     ocnt_q, ocnt_d;
  logic              ofull_q, ofull_d;
  logic              oempty_q, oempty_d;

  logic [KEY_W-1:0]  rkey;
  logic [PAY_W-1:0]  rpay;
  logic              key_eq, key_gt;
  logic              issue;
  logic              is_full, is_empty;
  logic              up_dir;
  logic [CW-1:0]     cnt_m1;

  assign rkey     = ram_rdata_i[REC_W-1:PAY_W];
  assign rpay     = ram_rdata_i[PAY_W-1:0];
  // shared comparator
  assign key_eq   = (rkey == key_q);
  assign key_gt   = (rkey > key_q);
  assign is_full  = (cnt_q == CAP_C);
  assign is_empty = (cnt_q == '0);
  assign cnt_m1   = cnt_q - ONE_C;
  assign up_dir   = (op_q == OP_INS_SORTED);

  // next-state logic
  always_comb begin
    state_d = state_q;  op_d = op_q;     key_d = key_q;   pay_d = pay_q;
    cnt_d   = cnt_q;    ptr_d = ptr_q;   rem_d = rem_q;   rv_d = 1'b0;
    ridx_d  = ridx_q;   hit_d = hit_q;   hitv_d = hitv_q; ins_d = ins_q;
    src_d   = src_q;    dst_d = dst_q;   st_d = st_q;     rk_d = rk_q;
    rp_d    = rp_q;
    ovld_d  = ovld_q & out_stall_i;
    ost_d   = ost_q;    okey_d = okey_q; opay_d = opay_q; ocnt_d = ocnt_q;
    ofull_d = ofull_q;  oempty_d = oempty_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = '0;
    ram_raddr_o = ptr_q[AW-1:0];
    issue       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = op_i;
          key_d  = key_i;
          pay_d  = payload_i;
          st_d   = ST_OK;
          rk_d   = '0;
          rp_d   = '0;
          ptr_d  = '0;
          hitv_d = 1'b0;
          state_d = S_FIN;
          case (op_i)
            OP_INS_FRONT: begin
              if (is_full) begin
                st_d = ST_RANGE;
              end else if (is_empty) begin
                ram_we_o    = 1'b1;
                ram_wdata_o = {key_i, payload_i};
                cnt_d       = cnt_q + ONE_C;
              end else begin
                src_d   = '0;
                dst_d   = cnt_q[AW-1:0];
                state_d = S_MV_RD;
              end
            end
            OP_INS_BACK: begin
              if (is_full) begin
                st_d = ST_RANGE;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = cnt_q[AW-1:0];
                ram_wdata_o = {key_i, payload_i};
                cnt_d       = cnt_q + ONE_C;
              end
            end
            OP_INS_SORTED: begin
              if (is_full) st_d = ST_RANGE;
              else state_d = S_SCAN;
            end
            OP_READ_POS: begin
              if (position_i == '0 || position_i > cnt_q) begin
                st_d = ST_RANGE;
              end else begin
                ptr_d   = position_i - ONE_C;
                state_d = S_RD_ISSUE;
              end
            end
            OP_FIND_KEY, OP_RM_KEY_SHIFT, OP_RM_KEY_SWAP: begin
              state_d = S_SCAN;
            end
            OP_RM_FRONT: begin
              if (is_empty) begin
                st_d = ST_RANGE;
              end else begin
                cnt_d = cnt_m1;
                if (cnt_m1 != '0) begin
                  src_d   = cnt_m1[AW-1:0];
                  dst_d   = '0;
                  state_d = S_MV_RD;
                end
              end
            end
            OP_RM_BACK: begin
              if (is_empty) st_d = ST_RANGE;
              else cnt_d = cnt_m1;
            end
            OP_READ_LAST: begin
              if (is_empty) begin
                st_d = ST_RANGE;
              end else begin
                ptr_d   = cnt_m1;
                state_d = S_RD_ISSUE;
              end
            end
            default: st_d = ST_RANGE;
          endcase
        end
      end

      // pipelined walk from the front: read ahead, compare what returns
      S_SCAN: begin
        issue  = (ptr_q < cnt_q);
        rv_d   = issue;
        ridx_d = ptr_q;
        if (issue) ptr_d = ptr_q + ONE_C;
        if (rv_q) begin
          case (op_q)
            OP_FIND_KEY: begin
              if (key_eq) begin
                rk_d    = rkey;
                rp_d    = rpay;
                rv_d    = 1'b0;
                state_d = S_FIN;
              end
            end
            OP_INS_SORTED: begin
              if (key_gt) begin
                ins_d   = ridx_q;
                rem_d   = cnt_q - ridx_q;
                ptr_d   = cnt_m1;
                rv_d    = 1'b0;
                state_d = S_SHIFT;
              end
            end
            default: begin
              if (key_eq) begin
                hit_d  = ridx_q;
                hitv_d = 1'b1;
              end
            end
          endcase
        end else if (!issue) begin
          case (op_q)
            OP_FIND_KEY: begin
              st_d    = ST_NOTFOUND;
              state_d = S_FIN;
            end
            OP_INS_SORTED: begin
              ins_d   = cnt_q;
              rem_d   = '0;
              state_d = S_SHIFT;
            end
            default: begin
              if (!hitv_q) begin
                st_d    = ST_NOTFOUND;
                state_d = S_FIN;
              end else begin
                cnt_d = cnt_m1;
                if (op_q == OP_RM_KEY_SHIFT) begin
                  rem_d   = cnt_m1 - hit_q;
                  ptr_d   = hit_q + ONE_C;
                  state_d = S_SHIFT;
                end else if (hit_q != cnt_m1) begin
                  src_d   = cnt_m1[AW-1:0];
                  dst_d   = hit_q[AW-1:0];
                  state_d = S_MV_RD;
                end else begin
                  state_d = S_FIN;
                end
              end
            end
          endcase
        end
      end

      // pipelined block move: up for ordered insert, down for removal
      S_SHIFT: begin
        issue  = (rem_q != '0);
        rv_d   = issue;
        ridx_d = ptr_q;
        if (issue) begin
          ptr_d = up_dir ? (ptr_q - ONE_C) : (ptr_q + ONE_C);
          rem_d = rem_q - ONE_C;
        end
        if (rv_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = up_dir ? AW'(ridx_q + ONE_C) : AW'(ridx_q - ONE_C);
          ram_wdata_o = ram_rdata_i;
        end else if (!issue) begin
          if (up_dir) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = ins_q[AW-1:0];
            ram_wdata_o = {key_q, pay_q};
            cnt_d       = cnt_q + ONE_C;
          end
          state_d = S_FIN;
        end
      end

      S_MV_RD: begin
        ram_raddr_o = src_q;
        state_d     = S_MV_WR;
      end

      S_MV_WR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = dst_q;
        ram_wdata_o = ram_rdata_i;
        state_d     = (op_q == OP_INS_FRONT) ? S_PUT : S_FIN;
      end

      // new record into the front slot
      S_PUT: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = {key_q, pay_q};
        cnt_d       = cnt_q + ONE_C;
        state_d     = S_FIN;
      end

      S_RD_ISSUE: state_d = S_RD_TAKE;

      S_RD_TAKE: begin
        rk_d    = rkey;
        rp_d    = rpay;
        state_d = S_FIN;
      end

      // load the result register once it is free
      S_FIN: begin
        if (!ovld_q || !out_stall_i) begin
          ovld_d   = 1'b1;
          ost_d    = st_q;
          okey_d   = rk_q;
          opay_d   = rp_q;
          ocnt_d   = cnt_q;
          ofull_d  = is_full;
          oempty_d = is_empty;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
      hitv_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
      hitv_q  <= hitv_d;
      ovld_q  <= ovld_d;
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    pay_q    <= pay_d;
    ptr_q    <= ptr_d;
    rem_q    <= rem_d;
    ridx_q   <= ridx_d;
    hit_q    <= hit_d;
    ins_q    <= ins_d;
    src_q    <= src_d;
    dst_q    <= dst_d;
    st_q     <= st_d;
    rk_q     <= rk_d;
    rp_q     <= rp_d;
    ost_q    <= ost_d;
    okey_q   <= okey_d;
    opay_q   <= opay_d;
    ocnt_q   <= ocnt_d;
    ofull_q  <= ofull_d;
    oempty_q <= oempty_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = ovld_q;
  assign status_o      = ost_q;
  assign out_key_o     = okey_q;
  assign out_payload_o = opay_q;
  assign count_o       = ocnt_q;
  assign full_res_o    = ofull_q;
  assign empty_res_o   = oempty_q;

endmodule

### hdl/keyed_sequential_list_table.sv
// Top level of the keyed sequential list table.
// Depends on kslt_pkg, kslt_ram and kslt_ctrl.
//
// Usage:
//  A fixed-capacity list of records (31-bit key, 64-bit payload). One op per
//  input beat on the item channel (in_valid_i / in_stall_o), one result beat
//  per item on the result channel (out_valid_o / out_stall_i) carrying
//  status, the record read, the count and the full and empty flags.
//  One item at a time. Inserts at the back, removal at the back and ops
//  refused at once go straight to the result stage; reads and front moves
//  first pass a RAM read. Find, removal by key and ordered insert walk the
//  record RAM through one shared key comparator, one entry per cycle; an
//  ordered insert or removal by shifting then makes a shift pass over the
//  moved entries. The single read port of the record RAM sets this pace.
//  in_stall_o is high while an item is being worked on.
//  Reset empties the list at once (count to zero); RAM contents are left
//  as they are and never read before written.
//  A stalled result holds in the output register; the next item is still
//  accepted and finishes up to its result, waiting there for the register.
`timescale 1ns / 1ps

module keyed_sequential_list_table import kslt_pkg::*; #(
  parameter int CAPACITY = KSLT_CAPACITY,
  localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [PAY_W-1:0]  payload_i,
  input  logic [CW-1:0]     position_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ST_W-1:0]   status_o,
  output logic [KEY_W-1:0]  out_key_o,
  output logic [PAY_W-1:0]  out_payload_o,
  output logic [CW-1:0]     count_o,
  output logic              full_res_o,
  output logic              empty_res_o
);

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [REC_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [REC_W-1:0] ram_rdata;

  // record store: key in the upper bits, payload below
  kslt_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer with shared comparator and result register
  kslt_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .key_i         (key_i),
    .payload_i     (payload_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .out_key_o     (out_key_o),
    .out_payload_o (out_payload_o),
    .count_o       (count_o),
    .full_res_o    (full_res_o),
    .empty_res_o   (empty_res_o),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata)
  );

endmodule

### hdl/kslt_check.sv
// Port-level checks of the keyed sequential list table, bound to the top.
// Depends on kslt_pkg.
`timescale 1ns / 1ps

module kslt_check import kslt_pkg::*; #(
  parameter int CAPACITY = KSLT_CAPACITY,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [ST_W-1:0]   status_o,
  input logic [KEY_W-1:0]  out_key_o,
  input logic [PAY_W-1:0]  out_payload_o,
  input logic [CW-1:0]     count_o,
  input logic              full_res_o,
  input logic              empty_res_o
);

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(count_o))
    else $error("stalled result beat changed");

  // flags agree with the count
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (full_res_o == (count_o == CAP_C)) && (empty_res_o == (count_o == '0)))
    else $error("full/empty flags disagree with count");

  // count never beyond capacity
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_o <= CAP_C)
    else $error("count beyond capacity");

  // failed ops carry no record
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> out_key_o == '0 && out_payload_o == '0)
    else $error("failed op returned a record");

  // a failed op leaves the count as it was
  a_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i ##1 out_valid_o && $changed(count_o) |->
      status_o == ST_OK)
    else $error("count changed on a failed op");

endmodule

bind keyed_sequential_list_table kslt_check #(.CAPACITY(CAPACITY)) u_kslt_check (.*);

### dv/kslt_checker.sv
// Checker for the keyed sequential list table: watches both channels,
// keeps its own copy of the list, predicts each result beat and compares.
// Depends on kslt_pkg.
`timescale 1ns / 1ps

module kslt_checker import kslt_pkg::*; #(
  parameter int CAPACITY = KSLT_CAPACITY,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [OP_W-1:0]  op_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [PAY_W-1:0] payload_i,
  input  logic [CW-1:0]    position_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [ST_W-1:0]  status_i,
  input  logic [KEY_W-1:0] out_key_i,
  input  logic [PAY_W-1:0] out_payload_i,
  input  logic [CW-1:0]    count_i,
  input  logic             full_res_i,
  input  logic             empty_res_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               list_count_o
);

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [KEY_W-1:0] rkey;
    logic [PAY_W-1:0] rpay;
    logic [CW-1:0]    count;
    logic             full;
    logic             empty;
  } list_result_t;

  logic [KEY_W-1:0] list_keys [CAPACITY];
  logic [PAY_W-1:0] list_pays [CAPACITY];
  int               list_len;
  list_result_t     expected_q [$];

  assign pending_o    = expected_q.size();
  assign list_count_o = list_len;

  // last slot holding k, or list_len when absent
  function automatic int last_slot(logic [KEY_W-1:0] k);
    int hit;
    hit = list_len;
    for (int i = 0; i < list_len; i++) if (list_keys[i] == k) hit = i;
    return hit;
  endfunction

  // Apply one op to the shadow list and return the result it yields.
  function automatic list_result_t apply_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                                            logic [PAY_W-1:0] p, logic [CW-1:0] pos);
    list_result_t r;
    int i;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_INS_FRONT, OP_INS_BACK, OP_INS_SORTED: begin
        if (list_len >= CAPACITY) r.status = ST_RANGE;
        else begin
          if (op == OP_INS_FRONT) begin
            i = 0;
            if (list_len > 0) begin
              list_keys[list_len] = list_keys[0];
              list_pays[list_len] = list_pays[0];
            end
          end else if (op == OP_INS_BACK) begin
            i = list_len;
          end else begin
            i = 0;
            while (i < list_len && list_keys[i] <= k) i++;
            for (int j = list_len; j > i; j--) begin
              list_keys[j] = list_keys[j-1];
              list_pays[j] = list_pays[j-1];
            end
          end
          list_keys[i] = k;
          list_pays[i] = p;
          list_len++;
        end
      end
      OP_READ_POS: begin
        if (pos == 0 || pos > list_len) r.status = ST_RANGE;
        else begin
          r.rkey = list_keys[pos-1];
          r.rpay = list_pays[pos-1];
        end
      end
      OP_FIND_KEY: begin
        r.status = ST_NOTFOUND;
        for (int j = 0; j < list_len; j++) begin
          if (list_keys[j] == k) begin
            r.status = ST_OK;
            r.rkey   = list_keys[j];
            r.rpay   = list_pays[j];
            break;
          end
        end
      end
      OP_RM_KEY_SHIFT, OP_RM_KEY_SWAP: begin
        i = last_slot(k);
        if (i >= list_len) r.status = ST_NOTFOUND;
        else begin
          list_len--;
          if (op == OP_RM_KEY_SHIFT) begin
            for (int j = i; j < list_len; j++) begin
              list_keys[j] = list_keys[j+1];
              list_pays[j] = list_pays[j+1];
            end
          end else begin
            list_keys[i] = list_keys[list_len];
            list_pays[i] = list_pays[list_len];
          end
        end
      end
      OP_RM_FRONT, OP_RM_BACK, OP_READ_LAST: begin
        if (list_len == 0) r.status = ST_RANGE;
        else if (op == OP_READ_LAST) begin
          r.rkey = list_keys[list_len-1];
          r.rpay = list_pays[list_len-1];
        end else begin
          list_len--;
          if (op == OP_RM_FRONT) begin
            list_keys[0] = list_keys[list_len];
            list_pays[0] = list_pays[list_len];
          end
        end
      end
      default: r.status = ST_RANGE;
    endcase
    r.count = list_len[CW-1:0];
    r.full  = (list_len == CAPACITY);
    r.empty = (list_len == 0);
    return r;
  endfunction

  // Predict on each accepted input beat, compare on each result beat.
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t e;
    if (!rst_ni) begin
      list_len     = 0;
      fail_count_o = 0;
      expected_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no expectation waiting");
          fail_count_o++;
        end else begin
          e = expected_q.pop_front();
          if (status_i !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status_i);
            fail_count_o++;
          end
          if (out_key_i !== e.rkey) begin
            $error("out_key: expected %0h, got %0h", e.rkey, out_key_i);
            fail_count_o++;
          end
          if (out_payload_i !== e.rpay) begin
            $error("out_payload: expected %0h, got %0h", e.rpay, out_payload_i);
            fail_count_o++;
          end
          if (count_i !== e.count) begin
            $error("count: expected %0d, got %0d", e.count, count_i);
            fail_count_o++;
          end
          if (full_res_i !== e.full) begin
            $error("full_res: expected %0b, got %0b", e.full, full_res_i);
            fail_count_o++;
          end
          if (empty_res_i !== e.empty) begin
            $error("empty_res: expected %0b, got %0b", e.empty, empty_res_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(apply_op(op_i, key_i, payload_i, position_i));
    end
  end

endmodule

### dv/testbench.sv
// Top of the keyed sequential list table testbench: clock, reset, stimulus
// and verdict. Depends on kslt_pkg, keyed_sequential_list_table and kslt_checker.
`timescale 1ns / 1ps

module testbench import kslt_pkg::*;;

  localparam int CAP = KSLT_CAPACITY;
  localparam int CW  = $clog2(CAP + 1);

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [OP_W-1:0]  op_i = '0;
  logic [KEY_W-1:0] key_i = '0;
  logic [PAY_W-1:0] payload_i = '0;
  logic [CW-1:0]    position_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [ST_W-1:0]  status_o;
  logic [KEY_W-1:0] out_key_o;
  logic [PAY_W-1:0] out_payload_o;
  logic [CW-1:0]    count_o;
  logic             full_res_o;
  logic             empty_res_o;
  int               fail_count;
  int               pending;
  int               list_count;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  logic [KEY_W-1:0] used_keys [$];

  always #5 clk_i = ~clk_i;

  keyed_sequential_list_table #(.CAPACITY(CAP)) dut (.*);

  kslt_checker #(.CAPACITY(CAP)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .op_i, .key_i,
    .payload_i, .position_i, .out_valid_i(out_valid_o), .out_stall_i,
    .status_i(status_o), .out_key_i(out_key_o), .out_payload_i(out_payload_o),
    .count_i(count_o), .full_res_i(full_res_o), .empty_res_i(empty_res_o),
    .fail_count_o(fail_count), .pending_o(pending), .list_count_o(list_count));

  // Receiver stall, redrawn each falling edge.
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_idle_pct);

  // Present one beat and hold it until accepted; valid is dropped by the
  // next beat's idle gap or by drain().
  task automatic send_beat(kslt_op_e op, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p,
                           logic [CW-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    key_i      <= k;
    payload_i  <= p;
    position_i <= pos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Random key drawn mostly from earlier keys so finds and removals hit.
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    if (used_keys.size() > 0 && $urandom_range(99) < 70)
      return used_keys[$urandom_range(used_keys.size() - 1)];
    case ($urandom_range(3))
      0: k = KEY_W'($urandom_range(15));
      1: k = '1 - KEY_W'($urandom_range(3));
      default: k = KEY_W'($urandom());
    endcase
    used_keys.push_back(k);
    if (used_keys.size() > 40) void'(used_keys.pop_front());
    return k;
  endfunction

  task automatic random_beat();
    int sel;
    logic [OP_W-1:0] op;
    sel = $urandom_range(99);
    // bias toward inserts while short, removals while long
    if (sel < 5) op = 4'($urandom_range(15, 10));
    else if (sel < 50 - (list_count * 20) / CAP) op = 4'($urandom_range(2));
    else op = 4'($urandom_range(9, 3));
    send_beat(kslt_op_e'(op), pick_key(), {$urandom(), $urandom()},
              CW'($urandom_range(list_count + 2)));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2 * CAP + 10) @(negedge clk_i);
  endtask

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty-list errors, extremes, every op, full list.
    send_beat(OP_RM_FRONT, '0, '0, '0);
    send_beat(OP_RM_BACK, '0, '0, '0);
    send_beat(OP_READ_LAST, '0, '0, '0);
    send_beat(OP_FIND_KEY, '0, '0, '0);
    send_beat(OP_RM_KEY_SHIFT, '0, '0, '0);
    send_beat(OP_INS_SORTED, 31'd5, 64'h1, '0);
    send_beat(OP_INS_SORTED, '1, '1, '0);
    send_beat(OP_INS_SORTED, '0, 64'h2, '0);
    send_beat(OP_INS_SORTED, 31'd5, 64'h3, '0);
    send_beat(OP_INS_FRONT, 31'd9, 64'h4, '0);
    send_beat(OP_INS_BACK, 31'd5, 64'hAAAA_5555_AAAA_5555, '0);
    send_beat(OP_READ_POS, '0, '0, '0);
    send_beat(OP_READ_POS, '0, '0, CW'(1));
    send_beat(OP_READ_POS, '0, '0, CW'(6));
    send_beat(OP_READ_POS, '0, '0, CW'(7));
    send_beat(OP_READ_POS, '0, '0, '1);
    send_beat(OP_FIND_KEY, 31'd5, '0, '0);
    send_beat(OP_RM_KEY_SHIFT, 31'd5, '0, '0);
    send_beat(OP_RM_KEY_SWAP, 31'd5, '0, '0);
    send_beat(OP_RM_KEY_SWAP, 31'd77, '0, '0);
    send_beat(OP_RM_FRONT, '0, '0, '0);
    send_beat(OP_READ_LAST, '0, '0, '0);
    send_beat(kslt_op_e'(4'd10), '1, '1, '1);
    send_beat(kslt_op_e'(4'd15), '0, '0, '0);
    drain();
    // Fill to capacity, then overflow every insert.
    while (list_count < CAP)
      send_beat(OP_INS_BACK, KEY_W'($urandom()), {$urandom(), $urandom()}, '0);
    send_beat(OP_INS_FRONT, '1, '1, '0);
    send_beat(OP_INS_SORTED, '0, '0, '0);
    send_beat(OP_INS_BACK, '0, '0, '0);
    send_beat(OP_READ_POS, '0, '0, CW'(CAP));
    while (list_count > 0) send_beat(OP_RM_BACK, '0, '0, '0);

    // Random phases with different idling.
    send_idle_pct = 8;  recv_idle_pct = 81;
    repeat (180) random_beat();
    drain();
    send_idle_pct = 81; recv_idle_pct = 8;
    repeat (180) random_beat();
    send_idle_pct = 0;  recv_idle_pct = 0;
    repeat (190) random_beat();

    drain();
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

### files.f
hdl/kslt_pkg.sv
hdl/kslt_ram.sv
hdl/kslt_ctrl.sv
hdl/keyed_sequential_list_table.sv
hdl/kslt_check.sv
dv/kslt_checker.sv
dv/testbench.sv
